// File: src/cdcg_pkg.sv
// ----------------------------------------------------------------------------
// cdcg_pkg
// Shared types and constants of the call depth and cycle guard.
// ----------------------------------------------------------------------------
package cdcg_pkg;

	// Stack store geometry.
	localparam int STACK_DEPTH = 256;
	localparam int ID_WIDTH    = 16;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Field widths fixed by the interface.
	localparam int FUNC_W   = 2;
	localparam int BLOCK_W  = 16;
	localparam int DEPTH_W  = 9;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX         = '1;
	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = DEPTH_W'(256);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ASK_ON_LIMIT = CFG_IDX_W'(1);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ENTER = 2'd0,
		FUNC_EXIT  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_DEPTH  = 2'd1,
		ST_CYCLE  = 2'd2,
		ST_NOROOM = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_limit;
		logic               ask_on_limit;
	} cfg_t;

	typedef struct packed {
		status_t            status;
		logic [DEPTH_W-1:0] depth;
		logic               terminated;
	} res_t;

endpackage

// File: src/cdcg_ram.sv
// ----------------------------------------------------------------------------
// cdcg_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cdcg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/cdcg_ctrl.sv
// ----------------------------------------------------------------------------
// cdcg_ctrl
// Sequencer of the guard: holds counts and flags, pushes into the stack RAM
// and scans older entries one per cycle for a repeated identifier.
// ----------------------------------------------------------------------------
module cdcg_ctrl
	import cdcg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  in_func,
	input  logic [BLOCK_W-1:0] in_id,
	input  logic               in_allow,
	input  cfg_t               cfg,
	output logic               res_valid,
	input  logic               res_take,
	output res_t               res
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                stop_q;
	logic                cmp_vld_s1;
	logic [ID_WIDTH-1:0] id_q;
	status_t             status_q;

	logic                accept;
	logic                is_enter;
	logic                limit_hit;
	logic                full;
	logic                ram_we;
	logic                ram_re;
	logic [ID_WIDTH-1:0] id_in;
	logic [ID_WIDTH-1:0] rd_data;
	logic                hit;
	logic                last_miss;
	logic [DEPTH_W-1:0]  depth_inc;
	logic [CNT_W-1:0]    count_inc;

	assign id_in     = ID_WIDTH'(in_id);
	assign depth_inc = (depth_q != DEPTH_MAX) ? depth_q + 1'b1 : depth_q;
	assign count_inc = count_q + 1'b1;

	// Outputs and datapath strobes.
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		accept    = in_valid && in_ready;
		is_enter  = (in_func == FUNC_ENTER);
		// A zero limit disables the depth limit.
		limit_hit = (cfg.depth_limit != '0) && (depth_q >= cfg.depth_limit) &&
			!(cfg.ask_on_limit && in_allow);
		full      = (count_q == CNT_W'(STACK_DEPTH));
		ram_we    = accept && is_enter && !limit_hit && !full;
		ram_re    = (state_q == S_SEARCH) && (idx_q != count_q);
		hit       = (state_q == S_SEARCH) && cmp_vld_s1 && (rd_data == id_q);
		last_miss = (state_q == S_SEARCH) && cmp_vld_s1 && !hit && (idx_q == count_q);
		res_valid = (state_q == S_DONE);
		res.status     = status_q;
		res.depth      = depth_q;
		res.terminated = stop_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (ram_we && (count_q != '0)) begin
						state_d = S_SEARCH;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SEARCH: begin
				if (hit || last_miss) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			depth_q    <= '0;
			stop_q     <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			idx_q      <= '0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= ram_re;
			if (ram_re) begin
				idx_q <= idx_q + 1'b1;
			end
			if (accept) begin
				idx_q <= '0;
				case (in_func)
					FUNC_ENTER: begin
						if (limit_hit || full) begin
							stop_q <= 1'b1;
						end else if (count_q == '0) begin
							count_q <= count_inc;
							depth_q <= depth_inc;
						end
					end
					FUNC_EXIT: begin
						if (depth_q != '0) begin
							depth_q <= depth_q - 1'b1;
						end
						if (count_q != '0) begin
							count_q <= count_q - 1'b1;
						end
					end
					FUNC_CLEAR: begin
						count_q <= '0;
						depth_q <= '0;
						stop_q  <= 1'b0;
					end
					default: ;
				endcase
			end
			if (hit) begin
				count_q <= count_inc;
				stop_q  <= 1'b1;
			end else if (last_miss) begin
				count_q <= count_inc;
				depth_q <= depth_inc;
			end
		end
	end

	// Payload registers of the item in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= id_in;
			if (is_enter && limit_hit) begin
				status_q <= ST_DEPTH;
			end else if (is_enter && full) begin
				status_q <= ST_NOROOM;
			end else begin
				status_q <= ST_OK;
			end
		end
		if (hit) begin
			status_q <= ST_CYCLE;
		end
	end

	cdcg_ram #(
		.WIDTH (ID_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (id_in),
		.re    (ram_re),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

endmodule

// File: src/call_depth_cycle_guard_unit.sv
// ----------------------------------------------------------------------------
// call_depth_cycle_guard_unit
// Call stack guard: depth limit, cycle detection and terminated flag.
// ----------------------------------------------------------------------------
// Usage. Each input word carries func (enter, exit, clear), block_id and
// allow_over_limit; each one yields exactly one result word with status,
// the nesting depth after the item and the terminated flag. Both channels
// use valid/ready. A separate configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes the depth limit (index 0) and ask_on_limit
// (index 1); it is always ready and should be used only while idle.
// Timing. Exit, clear and enter items that stop on the limit or on a full
// store, and enters on an empty stack, go from acceptance to S_DONE and
// then to the output register. An enter that pushes over N older entries
// scans the stack RAM one entry per cycle, ending early on a match; the
// single read port of the stack RAM sets this rate. One item is in work
// at a time.
// Reset. arst_n clears depth, count and terminated and loads a depth limit
// of 256 and ask_on_limit 0; the stack RAM itself is not cleared.
// Stall. The result sits in an output register; a new word is accepted
// while it waits, and the next result holds in the sequencer until the
// output register is taken.
// ----------------------------------------------------------------------------
module call_depth_cycle_guard_unit
	import cdcg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FUNC_W-1:0]     func,
	input  logic [BLOCK_W-1:0]    block_id,
	input  logic                  allow_over_limit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [DEPTH_W-1:0]    depth,
	output logic                  terminated,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	res_t res;
	logic res_valid;
	logic res_take;
	logic out_valid_q;
	res_t out_q;

	// Configuration registers; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_limit  <= DEPTH_LIMIT_RESET;
			cfg_q.ask_on_limit <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEPTH_LIMIT:  cfg_q.depth_limit  <= DEPTH_W'(cfg_data);
				CFG_ASK_ON_LIMIT: cfg_q.ask_on_limit <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cdcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_func   (func),
		.in_id     (block_id),
		.in_allow  (allow_over_limit),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// Output register: loads whenever it is empty or being emptied.
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign depth      = out_q.depth;
	assign terminated = out_q.terminated;

endmodule
